@@ src/calendar_date_normalizer_top_macros.svh @@
// ----------------------------------------------------------------------------
// calendar date normalizer assertion macros
// shared property forms for the checks in the normalizer modules
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_NORMALIZER_TOP_MACROS_SVH
`define CALENDAR_DATE_NORMALIZER_TOP_MACROS_SVH

// same-cycle implication
`define CDN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/cdn_pkg.sv @@
// ----------------------------------------------------------------------------
// calendar date normalizer package
// shared types, codes and calendar helper functions
// ----------------------------------------------------------------------------
package cdn_pkg;

  typedef logic signed [16:0] year_t;
  typedef logic signed [8:0]  month_t;
  typedef logic signed [12:0] day_t;
  typedef logic [4:0]         res25_t;

  localparam year_t       YEAR_MAX          = 17'sd32767;
  localparam logic [15:0] DIV25             = 16'd25;
  // ceil(2^21 / 25), quotient exact for every 16-bit magnitude
  localparam logic [16:0] DIV25_RECIP       = 17'd83887;
  localparam int          DIV25_RECIP_SHIFT = 21;

  typedef enum logic [1:0] {
    FUNC_NORM = 2'd0,
    FUNC_ADD  = 2'd1,
    FUNC_SUB  = 2'd2,
    FUNC_CMP  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REL_LESS    = 2'd0,
    REL_EQUAL   = 2'd1,
    REL_GREATER = 2'd2
  } rel_e;

  typedef enum logic [1:0] {
    SEASON_WINTER = 2'd0,
    SEASON_SPRING = 2'd1,
    SEASON_SUMMER = 2'd2,
    SEASON_AUTUMN = 2'd3
  } season_e;

  typedef struct packed {
    year_t  year;
    month_t month;
    day_t   day;
  } cdn_req_t;

  typedef struct packed {
    logic       start;
    logic       take;
  } cdn_ctl_t;

  typedef struct packed {
    logic       idle;
    logic       done;
  } cdn_sts_t;

  typedef struct packed {
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [1:0]  season;
  } cdn_res_t;

  typedef struct packed {
    logic        start;
    logic [15:0] mag;
  } m25_req_t;

  typedef struct packed {
    logic       done;
    res25_t     rem;
  } m25_rsp_t;

  // leap year from low year bits and divisibility by 25
  function automatic logic leap_f(logic [3:0] ylo, logic div25);
    return div25 ? (ylo == 4'd0) : (ylo[1:0] == 2'd0);
  endfunction

  function automatic logic [4:0] days_in_f(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic season_e season_f(logic [3:0] m);
    season_e s;
    if (m == 4'd12 || m <= 4'd2) begin
      s = SEASON_WINTER;
    end else if (m <= 4'd5) begin
      s = SEASON_SPRING;
    end else if (m <= 4'd8) begin
      s = SEASON_SUMMER;
    end else begin
      s = SEASON_AUTUMN;
    end
    return s;
  endfunction

endpackage

@@ src/cdn_ifs.sv @@
// ----------------------------------------------------------------------------
// calendar date normalizer channels
// valid/ready interfaces for the request and result transfers
// ----------------------------------------------------------------------------
interface cdn_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [13:0]        a_year;
  logic signed [7:0]  a_month;
  logic signed [11:0] a_day;
  logic [13:0]        b_year;
  logic signed [7:0]  b_month;
  logic signed [11:0] b_day;

  modport source (
    output valid, func, a_year, a_month, a_day, b_year, b_month, b_day,
    input  ready
  );
  modport sink (
    input  valid, func, a_year, a_month, a_day, b_year, b_month, b_day,
    output ready
  );
endinterface

interface cdn_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [1:0]  season;
  logic [1:0]  relation;

  modport source (
    output valid, out_year, out_month, out_day, season, relation,
    input  ready
  );
  modport sink (
    input  valid, out_year, out_month, out_day, season, relation,
    output ready
  );
endinterface

@@ src/cdn_mod25.sv @@
// ----------------------------------------------------------------------------
// calendar date normalizer residue unit
// remainder of a year magnitude by 25: reciprocal multiply, then one subtract
// ----------------------------------------------------------------------------
module cdn_mod25 import cdn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  m25_req_t req_i,
  output m25_rsp_t rsp_o
);

  logic [15:0] mag_q, mag_d;
  logic [11:0] quo_q, quo_d;
  res25_t      rem_q, rem_d;
  logic        mul_q, mul_d;
  logic        sub_q, sub_d;
  logic        done_q, done_d;
  logic [32:0] prod;
  logic [15:0] quo_x25;
  logic [15:0] rem_full;

  assign prod     = 33'(mag_q) * 33'(DIV25_RECIP);
  assign quo_x25  = 16'(quo_q) * DIV25;
  assign rem_full = mag_q - quo_x25;

  always_comb begin
    mag_d  = mag_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    mul_d  = 1'b0;
    sub_d  = 1'b0;
    done_d = 1'b0;
    if (req_i.start) begin
      mag_d = req_i.mag;
      mul_d = 1'b1;
    end else if (mul_q) begin
      quo_d = prod[DIV25_RECIP_SHIFT +: 12];
      sub_d = 1'b1;
    end else if (sub_q) begin
      rem_d  = rem_full[4:0];
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= mul_d;
      sub_q  <= sub_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ src/cdn_core.sv @@
// ----------------------------------------------------------------------------
// calendar date normalizer core
// sequencer for month wrap, residue setup and month-by-month day carry
// ----------------------------------------------------------------------------
`include "calendar_date_normalizer_top_macros.svh"

module cdn_core import cdn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cdn_ctl_t ctl_i,
  input  cdn_req_t req_i,
  output cdn_sts_t sts_o,
  output cdn_res_t res_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MON  = 5'b00010,
    ST_MOD  = 5'b00100,
    ST_DAY  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e   st_q, st_d;
  year_t    y_q, y_d;
  month_t   m_q, m_d;
  day_t     d_q, d_d;
  res25_t   r25_q, r25_d;

  m25_req_t m25_req;
  m25_rsp_t m25_rsp;

  logic [3:0] m4, m_next, m_prev, y_prev_lo;
  logic       wrap_dn;
  res25_t     r25_inc, r25_dec, r25_prev, r25_init;
  day_t       dim_cur, dim_prev;

  cdn_mod25 u_mod25 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (m25_req),
    .rsp_o (m25_rsp)
  );

  assign m4        = m_q[3:0];
  assign m_next    = (m4 == 4'd12) ? 4'd1 : m4 + 4'd1;
  assign wrap_dn   = (m4 == 4'd1);
  assign m_prev    = wrap_dn ? 4'd12 : m4 - 4'd1;
  assign y_prev_lo = wrap_dn ? y_q[3:0] - 4'd1 : y_q[3:0];
  assign r25_inc   = (r25_q == 5'd24) ? 5'd0 : r25_q + 5'd1;
  assign r25_dec   = (r25_q == 5'd0) ? 5'd24 : r25_q - 5'd1;
  assign r25_prev  = wrap_dn ? r25_dec : r25_q;
  assign r25_init  = (y_q[16] && m25_rsp.rem != 5'd0) ? 5'd25 - m25_rsp.rem : m25_rsp.rem;
  assign dim_cur   = day_t'(days_in_f(m4, leap_f(y_q[3:0], r25_q == 5'd0)));
  assign dim_prev  = day_t'(days_in_f(m_prev, leap_f(y_prev_lo, r25_prev == 5'd0)));

  always_comb begin
    st_d          = st_q;
    y_d           = y_q;
    m_d           = m_q;
    d_d           = d_q;
    r25_d         = r25_q;
    m25_req.start = 1'b0;
    m25_req.mag   = y_q[16] ? 16'(-y_q) : y_q[15:0];
    unique case (st_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          y_d  = req_i.year;
          m_d  = req_i.month;
          d_d  = req_i.day;
          st_d = ST_MON;
        end
      end
      ST_MON: begin
        if (m_q > 9'sd12) begin
          m_d = m_q - 9'sd12;
          y_d = y_q + 17'sd1;
        end else if (m_q < 9'sd1) begin
          m_d = m_q + 9'sd12;
          y_d = y_q - 17'sd1;
        end else begin
          m25_req.start = 1'b1;
          st_d          = ST_MOD;
        end
      end
      ST_MOD: begin
        if (m25_rsp.done) begin
          r25_d = r25_init;
          st_d  = ST_DAY;
        end
      end
      ST_DAY: begin
        if (d_q > dim_cur) begin
          d_d = d_q - dim_cur;
          m_d = month_t'(m_next);
          if (m4 == 4'd12) begin
            y_d   = y_q + 17'sd1;
            r25_d = r25_inc;
          end
        end else if (d_q < 13'sd1) begin
          d_d = d_q + dim_prev;
          m_d = month_t'(m_prev);
          if (wrap_dn) begin
            y_d   = y_q - 17'sd1;
            r25_d = r25_dec;
          end
        end else begin
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (ctl_i.take) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q   <= y_d;
    m_q   <= m_d;
    d_q   <= d_d;
    r25_q <= r25_d;
  end

  // year floor and saturation
  assign res_o.year   = (y_q < 17'sd1) ? 15'd1 :
                        (y_q > YEAR_MAX) ? YEAR_MAX[14:0] : y_q[14:0];
  assign res_o.month  = m4;
  assign res_o.day    = d_q[4:0];
  assign res_o.season = season_f(m4);

  assign sts_o.idle = (st_q == ST_IDLE);
  assign sts_o.done = (st_q == ST_FIN);

  `CDN_ASSERT_IMPL(a_day_month_range, st_q == ST_DAY, (m_q >= 9'sd1) && (m_q <= 9'sd12), "month out of range in day carry")
  `CDN_ASSERT_IMPL(a_residue_range, st_q == ST_DAY, r25_q < 5'd25, "year residue out of range")
  `CDN_ASSERT_IMPL(a_fin_day_range, st_q == ST_FIN, (d_q >= 13'sd1) && (d_q <= 13'sd31), "final day out of range")

endmodule

@@ src/calendar_date_normalizer_top.sv @@
// ----------------------------------------------------------------------------
// calendar date normalizer top: per item, W month wraps and then D month steps of day carry
// W <= 22 and D <= about 140 for the input ranges, one item in flight, next taken after result
// throughput set by the month-a-cycle day carry and held back by result stalls
// reset: asynchronous active low, clears sequencer and output valid, no clearing pass
// ----------------------------------------------------------------------------
`include "calendar_date_normalizer_top_macros.svh"

module calendar_date_normalizer_top import cdn_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  cdn_in_if.sink   in_i,
  cdn_out_if.source out_o
);

  cdn_ctl_t ctl;
  cdn_sts_t sts;
  cdn_req_t req;
  cdn_res_t res;

  func_e    func;
  rel_e     rel_raw;
  rel_e     rel_q;
  logic     in_xfer;
  logic     load;

  logic        out_valid_q, out_valid_d;
  logic [14:0] out_year_q;
  logic [3:0]  out_month_q;
  logic [4:0]  out_day_q;
  logic [1:0]  season_q;
  logic [1:0]  relation_q;

  year_t  ay, by;
  month_t am, bm;
  day_t   ad, bd;

  assign func = func_e'(in_i.func);
  assign ay   = year_t'(in_i.a_year);
  assign by   = year_t'(in_i.b_year);
  assign am   = month_t'(in_i.a_month);
  assign bm   = month_t'(in_i.b_month);
  assign ad   = day_t'(in_i.a_day);
  assign bd   = day_t'(in_i.b_day);

  always_comb begin
    unique case (func)
      FUNC_ADD: begin
        req.year  = ay + by;
        req.month = am + bm;
        req.day   = ad + bd;
      end
      FUNC_SUB: begin
        req.year  = ay - by;
        req.month = am - bm;
        req.day   = ad - bd;
      end
      default: begin
        req.year  = ay;
        req.month = am;
        req.day   = ad;
      end
    endcase
  end

  always_comb begin
    if (in_i.a_year != in_i.b_year) begin
      rel_raw = (in_i.a_year < in_i.b_year) ? REL_LESS : REL_GREATER;
    end else if (in_i.a_month != in_i.b_month) begin
      rel_raw = (in_i.a_month < in_i.b_month) ? REL_LESS : REL_GREATER;
    end else if (in_i.a_day != in_i.b_day) begin
      rel_raw = (in_i.a_day < in_i.b_day) ? REL_LESS : REL_GREATER;
    end else begin
      rel_raw = REL_EQUAL;
    end
  end

  assign in_i.ready = sts.idle;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign load       = sts.done && (!out_valid_q || out_o.ready);

  assign ctl.start = in_xfer;
  assign ctl.take  = load;

  cdn_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .req_i (req),
    .sts_o (sts),
    .res_o (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rel_q <= rel_raw;
    end
    if (load) begin
      out_year_q  <= res.year;
      out_month_q <= res.month;
      out_day_q   <= res.day;
      season_q    <= res.season;
      relation_q  <= rel_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_year  = out_year_q;
  assign out_o.out_month = out_month_q;
  assign out_o.out_day   = out_day_q;
  assign out_o.season    = season_q;
  assign out_o.relation  = relation_q;

  `CDN_ASSERT_NEXT(a_busy_after_transfer, in_i.valid && in_i.ready, !in_i.ready, "ready after input transfer")
  `CDN_ASSERT_IMPL(a_out_month_range, out_valid_q, (out_month_q >= 4'd1) && (out_month_q <= 4'd12), "result month out of range")
  `CDN_ASSERT_IMPL(a_out_year_nonzero, out_valid_q, out_year_q != 15'd0, "result year zero")

endmodule

@@ dv/calendar_date_normalizer_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar date normalizer testbench
// directed and random date requests through the valid/ready channels, each
// result checked field by field against an in-order prediction of the
// normalized date, its season and the relation of raw A to B, under phases
// of sender idling and receiver stalling
// ----------------------------------------------------------------------------
module calendar_date_normalizer_top_tb;
  import cdn_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE       = 200;

  typedef struct {
    func_e              func;
    logic [13:0]        a_year;
    logic signed [7:0]  a_month;
    logic signed [11:0] a_day;
    logic [13:0]        b_year;
    logic signed [7:0]  b_month;
    logic signed [11:0] b_day;
  } date_req_t;

  typedef struct {
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    season_e     season;
    rel_e        relation;
  } date_res_t;

  class date_checker;
    date_res_t pending_dates[$];
    int        mismatches;

    function int days_of_month(int m, int y);
      int len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      logic leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      if (m == 2 && leap) return 29;
      return len[m - 1];
    endfunction

    function date_res_t normalize_date(date_req_t r);
      date_res_t e;
      int ay, am, ad, by, bm, bd;
      int y, m, d, q, rm;
      ay = int'(r.a_year);
      am = int'(r.a_month);
      ad = int'(r.a_day);
      by = int'(r.b_year);
      bm = int'(r.b_month);
      bd = int'(r.b_day);
      case (r.func)
        FUNC_ADD: begin
          y = ay + by;
          m = am + bm;
          d = ad + bd;
        end
        FUNC_SUB: begin
          y = ay - by;
          m = am - bm;
          d = ad - bd;
        end
        default: begin
          y = ay;
          m = am;
          d = ad;
        end
      endcase
      // floor division of month offset by twelve
      q  = (m - 1) / 12;
      rm = (m - 1) % 12;
      if (rm < 0) begin
        rm += 12;
        q  -= 1;
      end
      y += q;
      m = rm + 1;
      while (d > days_of_month(m, y)) begin
        d -= days_of_month(m, y);
        m++;
        if (m > 12) begin
          m = 1;
          y++;
        end
      end
      while (d < 1) begin
        m--;
        if (m < 1) begin
          m = 12;
          y--;
        end
        d += days_of_month(m, y);
      end
      if (y < 1) y = 1;
      if (y > 32767) y = 32767;
      e.year  = 15'(y);
      e.month = 4'(m);
      e.day   = 5'(d);
      if (m == 12 || m <= 2) e.season = SEASON_WINTER;
      else if (m <= 5) e.season = SEASON_SPRING;
      else if (m <= 8) e.season = SEASON_SUMMER;
      else e.season = SEASON_AUTUMN;
      if (ay != by) e.relation = (ay < by) ? REL_LESS : REL_GREATER;
      else if (am != bm) e.relation = (am < bm) ? REL_LESS : REL_GREATER;
      else if (ad != bd) e.relation = (ad < bd) ? REL_LESS : REL_GREATER;
      else e.relation = REL_EQUAL;
      return e;
    endfunction

    function void note_request(date_req_t r);
      pending_dates.push_back(normalize_date(r));
    endfunction

    function void check_result(date_res_t got);
      date_res_t e;
      if (pending_dates.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result %0d-%0d-%0d s%0d r%0d", got.year, got.month,
                   got.day, got.season, got.relation);
        mismatches++;
        return;
      end
      e = pending_dates.pop_front();
      if (got.year != e.year || got.month != e.month || got.day != e.day ||
          got.season != e.season || got.relation != e.relation) begin
        if (mismatches < 10)
          $display("date mismatch: exp %0d-%0d-%0d s%0d r%0d got %0d-%0d-%0d s%0d r%0d",
                   e.year, e.month, e.day, e.season, e.relation,
                   got.year, got.month, got.day, got.season, got.relation);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycles;

  date_checker chk = new;
  date_req_t   directed_q[$];

  cdn_in_if  req_if ();
  cdn_out_if res_if ();

  calendar_date_normalizer_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if.sink),
    .out_o  (res_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // result side: sample on the edge, then decide the next ready
  initial begin
    date_res_t got;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        got.year     = res_if.out_year;
        got.month    = res_if.out_month;
        got.day      = res_if.out_day;
        got.season   = season_e'(res_if.season);
        got.relation = rel_e'(res_if.relation);
        chk.check_result(got);
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void add_directed(func_e f, int ay, int am, int ad,
                                       int by, int bm, int bd);
    date_req_t r;
    r.func    = f;
    r.a_year  = 14'(ay);
    r.a_month = 8'(am);
    r.a_day   = 12'(ad);
    r.b_year  = 14'(by);
    r.b_month = 8'(bm);
    r.b_day   = 12'(bd);
    directed_q.push_back(r);
  endfunction

  function automatic date_req_t rand_request();
    date_req_t r;
    int        mode;
    mode      = $urandom_range(9);
    r.func    = func_e'($urandom_range(3));
    r.a_year  = 14'($urandom);
    r.a_month = 8'($urandom);
    r.a_day   = 12'($urandom);
    r.b_year  = 14'($urandom);
    r.b_month = 8'($urandom);
    r.b_day   = 12'($urandom);
    case (mode)
      4, 5: begin
        r.a_month = 8'($urandom_range(12, 1));
        r.a_day   = 12'($urandom_range(31, 1));
        r.b_year  = 14'($urandom_range(30));
        r.b_month = 8'($urandom_range(12));
        r.b_day   = 12'($urandom_range(60));
      end
      6: begin
        r.b_year  = r.a_year;
        r.b_month = r.a_month;
        r.b_day   = r.a_day;
        case ($urandom_range(3))
          1: r.b_day = 12'($urandom);
          2: r.b_month = 8'($urandom);
          3: r.b_year = 14'($urandom);
          default: ;
        endcase
      end
      7: begin
        r.func   = ($urandom_range(1) != 0) ? FUNC_SUB : FUNC_NORM;
        r.a_year = 14'($urandom_range(8));
        r.b_year = 14'($urandom_range(8));
      end
      8: begin
        r.func   = FUNC_ADD;
        r.a_year = 14'(16383 - $urandom_range(3));
        r.b_year = 14'(16383 - $urandom_range(3));
      end
      9: begin
        r.func    = FUNC_NORM;
        r.a_year  = 14'(($urandom_range(1) != 0) ? 100 * $urandom_range(163)
                                                 : 4 * $urandom_range(4095));
        r.a_month = 8'($urandom_range(3, 2));
        r.a_day   = 12'(int'($urandom_range(31)) - 1);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(input date_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.func    <= r.func;
    req_if.a_year  <= r.a_year;
    req_if.a_month <= r.a_month;
    req_if.a_day   <= r.a_day;
    req_if.b_year  <= r.b_year;
    req_if.b_month <= r.b_month;
    req_if.b_day   <= r.b_day;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    chk.note_request(r);
  endtask

  task automatic wait_drained();
    if (chk.pending() != 0) begin
      req_if.valid <= 1'b0;
      while (chk.pending() != 0) @(posedge clk);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      send_request(rand_request());
      if (i == n / 2 || $urandom_range(49) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    req_if.valid   = 1'b0;
    req_if.func    = FUNC_NORM;
    req_if.a_year  = '0;
    req_if.a_month = '0;
    req_if.a_day   = '0;
    req_if.b_year  = '0;
    req_if.b_month = '0;
    req_if.b_day   = '0;

    add_directed(FUNC_NORM, 2024, 2, 29, 0, 0, 0);
    add_directed(FUNC_NORM, 1900, 2, 29, 1900, 2, 29);
    add_directed(FUNC_NORM, 2000, 2, 29, 2000, 2, 30);
    add_directed(FUNC_NORM, 2100, 3, 0, 1, 1, 1);
    add_directed(FUNC_NORM, 0, 2, 29, 0, 2, 29);
    add_directed(FUNC_NORM, 0, 0, 0, 0, 0, 0);
    add_directed(FUNC_NORM, 2023, 13, 0, 2023, 12, 31);
    add_directed(FUNC_NORM, 16383, 127, 2047, 16383, 127, 2047);
    add_directed(FUNC_NORM, 16383, -128, -2048, 0, 0, 0);
    add_directed(FUNC_NORM, 1, -128, 1, 1, 1, 1);
    add_directed(FUNC_ADD, 16383, 127, 2047, 16383, 127, 2047);
    add_directed(FUNC_ADD, 2023, 12, 31, 0, 0, 1);
    add_directed(FUNC_ADD, 0, -128, -2048, 0, -128, -2048);
    add_directed(FUNC_SUB, 0, -128, -2048, 16383, 127, 2047);
    add_directed(FUNC_SUB, 5, 3, 1, 9, 0, 1);
    add_directed(FUNC_SUB, 2000, 1, 1, 2000, 1, 1);
    add_directed(FUNC_CMP, 2024, 5, 10, 2025, 1, 1);
    add_directed(FUNC_CMP, 2024, 5, 10, 2024, 6, 1);
    add_directed(FUNC_CMP, 2024, 5, 10, 2024, 5, 9);
    add_directed(FUNC_CMP, 2024, -3, 10, 2024, -3, 10);
    add_directed(FUNC_CMP, 2025, 1, 1, 2024, 12, 31);
    add_directed(FUNC_CMP, 16383, 127, 2047, 0, -128, -2048);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[i]) send_request(directed_q[i]);
    wait_drained();

    run_phase(0, 0, RANDOM_ITEMS / 4);
    run_phase(82, 0, RANDOM_ITEMS / 4);
    run_phase(0, 82, RANDOM_ITEMS / 4);
    run_phase(31, 31, RANDOM_ITEMS / 4);

    repeat (SETTLE) @(posedge clk);
    if (chk.mismatches == 0 && chk.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ calendar_date_normalizer_top.f @@
+incdir+src
src/cdn_pkg.sv
src/cdn_ifs.sv
src/cdn_mod25.sv
src/cdn_core.sv
src/calendar_date_normalizer_top.sv
dv/calendar_date_normalizer_top_tb.sv
